// ===== rtl/core/random_draw_multiset_store_assert.svh =====
// Assertion macros for the random draw bag.
// Expects clk and rst_n in the scope of each use.
`ifndef RANDOM_DRAW_MULTISET_STORE_ASSERT_SVH
`define RANDOM_DRAW_MULTISET_STORE_ASSERT_SVH

`define RDMS_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`define RDMS_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== rtl/core/rdms_pkg.sv =====
// Shared types and constants for the random draw bag.
// No dependencies.
package rdms_pkg;

    localparam int DEF_CAPACITY = 256;
    localparam int VAL_W        = 32;
    localparam int RW_W         = 31;
    localparam int CNT_OUT_W    = 9;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DRAW   = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]           opcode;
        logic signed [VAL_W-1:0] item_value;
        logic [RW_W-1:0]      random_word;
    } cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] drawn_value;
        logic [CNT_OUT_W-1:0] match_count;
        logic [1:0]           status;
        logic [CNT_OUT_W-1:0] occupancy;
    } rsp_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MOD   = 7'b0000010,
        S_PICK  = 7'b0000100,
        S_GRAB  = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_SCAN  = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

endpackage

// ===== rtl/core/rdms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on rdms_pkg for default sizes.
module rdms_ram #(
    parameter int WIDTH = rdms_pkg::VAL_W,
    parameter int DEPTH = rdms_pkg::DEF_CAPACITY
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/rdms_mod.sv =====
// Bit-serial restoring remainder unit: random word modulo occupancy.
// Depends on rdms_pkg; one quotient bit per cycle.
module rdms_mod #(
    parameter int CAPACITY = rdms_pkg::DEF_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rdms_pkg::RW_W-1:0]         dividend,
    input  logic [$clog2(CAPACITY+1)-1:0]     divisor,
    output logic                              done,
    output logic [$clog2(CAPACITY+1)-1:0]     remainder
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int RW_W   = rdms_pkg::RW_W;
    localparam int STEP_W = $clog2(RW_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RW_W-1:0]   dvd_reg, dvd_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    diff;

    always_comb
    begin
        rem_sh    = {rem_reg, dvd_reg[RW_W-1]};
        diff      = rem_sh - {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(RW_W - 1);
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = (rem_sh >= {1'b0, div_reg}) ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            dvd_next = dvd_reg << 1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        dvd_reg  <= dvd_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/random_draw_multiset_store.sv =====
// Random draw bag: holds up to CAPACITY signed 32-bit values in one RAM and
// serves one command beat at a time; cmd_stall is high from acceptance until
// the response is loaded. Peek scans the occupied entries through the single
// RAM read port, one entry a cycle. Draw runs the bit-serial modulo unit on
// the random word, then moves each entry above the drawn index down one place
// through the RAM. Every command waits in finish while the previous response
// beat is still stalled. No clearing pass after reset.
// Depends on rdms_pkg, rdms_ram, rdms_mod and the assertion macro header.
`include "random_draw_multiset_store_assert.svh"

module random_draw_multiset_store #(
    parameter int CAPACITY = rdms_pkg::DEF_CAPACITY
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  rdms_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output rdms_pkg::rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int VAL_W = rdms_pkg::VAL_W;
    localparam int OUT_W = rdms_pkg::CNT_OUT_W;

    rdms_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] match_reg, match_next;
    logic             chk_reg, chk_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [VAL_W-1:0] drawn_reg, drawn_next;
    logic [1:0]       status_reg, status_next;
    rdms_pkg::rsp_t   rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic             accept;
    logic [CNT_W:0]   ptr_p1, ptr_p2, cnt_x;

    logic             we;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [VAL_W-1:0] wr_data, rd_data;

    logic             mod_start, mod_done;
    logic [CNT_W-1:0] mod_rem;

    rdms_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rdms_mod #(
        .CAPACITY (CAPACITY)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (cmd.random_word),
        .divisor   (cnt_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign cmd_stall = (state_reg != rdms_pkg::S_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign ptr_p1    = {1'b0, ptr_reg} + 1'b1;
    assign ptr_p2    = {1'b0, ptr_reg} + 2'd2;
    assign cnt_x     = {1'b0, cnt_reg};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        match_next     = match_reg;
        chk_next       = chk_reg;
        val_next       = val_reg;
        drawn_next     = drawn_reg;
        status_next    = status_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        we             = 1'b0;
        wr_addr        = cnt_reg[IDX_W-1:0];
        wr_data        = cmd.item_value;
        rd_addr        = ptr_reg[IDX_W-1:0];
        mod_start      = 1'b0;

        unique case (state_reg)
            rdms_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    val_next    = cmd.item_value;
                    drawn_next  = '0;
                    match_next  = '0;
                    status_next = rdms_pkg::ST_OK;
                    ptr_next    = '0;
                    chk_next    = 1'b0;
                    state_next  = rdms_pkg::S_FIN;
                    unique case (cmd.opcode)
                        rdms_pkg::OP_INSERT:
                        begin
                            if (cnt_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = rdms_pkg::ST_FULL;
                            end
                            else
                            begin
                                we       = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        rdms_pkg::OP_DRAW:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = rdms_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                mod_start  = 1'b1;
                                state_next = rdms_pkg::S_MOD;
                            end
                        end
                        rdms_pkg::OP_PEEK:
                        begin
                            state_next = rdms_pkg::S_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            rdms_pkg::S_MOD:
            begin
                if (mod_done)
                begin
                    ptr_next   = mod_rem;
                    state_next = rdms_pkg::S_PICK;
                end
            end
            rdms_pkg::S_PICK:
            begin
                state_next = rdms_pkg::S_GRAB;
            end
            rdms_pkg::S_GRAB:
            begin
                drawn_next = rd_data;
                if (ptr_p1 < cnt_x)
                begin
                    rd_addr    = ptr_p1[IDX_W-1:0];
                    state_next = rdms_pkg::S_SHIFT;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = rdms_pkg::S_FIN;
                end
            end
            rdms_pkg::S_SHIFT:
            begin
                we       = 1'b1;
                wr_addr  = ptr_reg[IDX_W-1:0];
                wr_data  = rd_data;
                ptr_next = ptr_p1[CNT_W-1:0];
                if (ptr_p2 < cnt_x)
                begin
                    rd_addr = ptr_p2[IDX_W-1:0];
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = rdms_pkg::S_FIN;
                end
            end
            rdms_pkg::S_SCAN:
            begin
                if (chk_reg && (rd_data == val_reg))
                begin
                    match_next = match_reg + 1'b1;
                end
                if (ptr_reg < cnt_reg)
                begin
                    chk_next = 1'b1;
                    ptr_next = ptr_p1[CNT_W-1:0];
                end
                else
                begin
                    chk_next   = 1'b0;
                    state_next = rdms_pkg::S_FIN;
                end
            end
            rdms_pkg::S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.drawn_value = drawn_reg;
                    rsp_next.match_count = OUT_W'(match_reg);
                    rsp_next.status      = status_reg;
                    rsp_next.occupancy   = OUT_W'(cnt_reg);
                    rsp_valid_next       = 1'b1;
                    state_next           = rdms_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rdms_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rdms_pkg::S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        match_reg  <= match_next;
        chk_reg    <= chk_next;
        val_reg    <= val_next;
        drawn_reg  <= drawn_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `RDMS_NEVER(a_cnt_cap, cnt_reg > CNT_W'(CAPACITY), "occupancy above capacity")
    `RDMS_CHECK(a_rsp_from_fin, $rose(rsp_valid_reg) |-> $past(state_reg == rdms_pkg::S_FIN), "response beat raised outside finish")
    `RDMS_CHECK(a_shift_bound, state_reg == rdms_pkg::S_SHIFT |-> ptr_p1 < cnt_x, "shift past occupied entries")
    `RDMS_CHECK(a_peek_keeps_cnt, accept && cmd.opcode == rdms_pkg::OP_PEEK |=> cnt_reg == $past(cnt_reg), "peek changed occupancy")
    `RDMS_CHECK(a_match_bound, state_reg == rdms_pkg::S_SCAN |-> match_reg <= cnt_reg, "match count above occupancy")

endmodule
